// File: sv/srtn_pkg.sv
// shared types, constants and helpers for the srtn scheduler
package srtn_pkg;

    localparam int MAX_PROCS = 16;
    localparam int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W     = $clog2(MAX_PROCS + 1);
    localparam int VAL_W     = 10;
    localparam int TIME_W    = $clog2(((1 << VAL_W) * (MAX_PROCS + 1)) + 1);
    localparam int OUT_W     = 15;
    localparam int SUM_W     = 19;
    localparam int PNUM_W    = 5;
    localparam int CMP_W     = (TIME_W > OUT_W) ? TIME_W : OUT_W;

    localparam logic [OUT_W-1:0] OUT_MAX = '1;
    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    typedef struct packed {
        logic [VAL_W-1:0] arr_tick;
        logic [VAL_W-1:0] burst_len;
        logic             last_process;
    } in_item_t;

    typedef struct packed {
        logic [PNUM_W-1:0] process_number;
        logic [OUT_W-1:0]  turnaround;
        logic [OUT_W-1:0]  waiting;
        logic [OUT_W-1:0]  response;
        logic [SUM_W-1:0]  sum_waiting;
        logic [SUM_W-1:0]  sum_turnaround;
        logic [SUM_W-1:0]  sum_response;
        logic              final_result;
    } out_item_t;

    typedef struct packed {
        logic [VAL_W-1:0] arrival;
        logic [VAL_W-1:0] burst;
        logic [VAL_W-1:0] remaining;
        logic [OUT_W-1:0] response;
    } entry_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } mem_wr_t;

    typedef struct packed {
        logic      valid;
        out_item_t item;
    } res_t;

    function automatic logic [OUT_W-1:0] sat_out(input logic [TIME_W-1:0] v);
        logic [OUT_W-1:0] r;
        if (CMP_W'(v) > CMP_W'(OUT_MAX)) begin
            r = OUT_MAX;
        end else begin
            r = OUT_W'(v);
        end
        return r;
    endfunction

    function automatic logic [SUM_W-1:0] sum_add(input logic [SUM_W-1:0] acc,
                                                 input logic [OUT_W-1:0] v);
        logic [SUM_W:0] s;
        s = {1'b0, acc} + (SUM_W + 1)'(v);
        return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
    endfunction

endpackage

// File: sv/srtn_store.sv
// process record memory, one write port and one registered read port
module srtn_store (
    input  logic                       aclk,
    input  srtn_pkg::mem_wr_t          wr,
    input  logic [srtn_pkg::IDX_W-1:0] rd_addr,
    output srtn_pkg::entry_t           rd_data
);

    srtn_pkg::entry_t mem [srtn_pkg::MAX_PROCS];
    srtn_pkg::entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/srtn_seq.sv
// load, scan, update and completion sequencer of the srtn scheduler
module srtn_seq (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  srtn_pkg::in_item_t         s_data,
    output srtn_pkg::mem_wr_t          wr,
    output logic [srtn_pkg::IDX_W-1:0] rd_addr,
    input  srtn_pkg::entry_t           rd_data,
    output srtn_pkg::res_t             res,
    input  logic                       slot_free
);

    typedef enum logic [2:0] {
        IDLE, SCAN, DECIDE, UPDATE, FIN, SUMS, EMIT
    } state_t;

    state_t state_reg, state_next;

    logic [srtn_pkg::CNT_W-1:0]     loaded_reg, loaded_next;
    logic [srtn_pkg::CNT_W-1:0]     done_reg, done_next;
    logic [srtn_pkg::TIME_W-1:0]    time_reg, time_next;
    logic [srtn_pkg::SUM_W-1:0]     tot_w_reg, tot_w_next;
    logic [srtn_pkg::SUM_W-1:0]     tot_t_reg, tot_t_next;
    logic [srtn_pkg::SUM_W-1:0]     tot_r_reg, tot_r_next;
    logic [srtn_pkg::MAX_PROCS-1:0] started_reg, started_next;
    logic [srtn_pkg::IDX_W-1:0]     rd_idx_reg, rd_idx_next;
    logic                           cmp_valid_reg, cmp_valid_next;
    logic [srtn_pkg::IDX_W-1:0]     cmp_idx_reg, cmp_idx_next;
    logic                           found_reg, found_next;
    logic [srtn_pkg::IDX_W-1:0]     best_idx_reg, best_idx_next;
    srtn_pkg::entry_t               best_reg, best_next;
    logic [srtn_pkg::IDX_W-1:0]     sel_idx_reg, sel_idx_next;
    srtn_pkg::entry_t               sel_reg, sel_next;
    logic                           sel_started_reg, sel_started_next;
    logic [srtn_pkg::TIME_W-1:0]    tat_reg, tat_next;
    logic [srtn_pkg::OUT_W-1:0]     rt_reg, rt_next;
    srtn_pkg::out_item_t            res_reg, res_next;

    logic                           cand;
    logic                           found_now;
    logic [srtn_pkg::IDX_W-1:0]     best_idx_now;
    srtn_pkg::entry_t               best_now;
    logic [srtn_pkg::VAL_W-1:0]     load_burst;
    logic [srtn_pkg::OUT_W-1:0]     new_resp;
    logic [srtn_pkg::SUM_W-1:0]     add_w, add_t, add_r;

    // running minimum over the scanned entries, lowest index wins ties
    always_comb begin
        cand = cmp_valid_reg
            && (srtn_pkg::TIME_W'(rd_data.arrival) <= time_reg)
            && (rd_data.remaining != '0)
            && (!found_reg || (rd_data.remaining < best_reg.remaining));
        found_now    = found_reg | cand;
        best_idx_now = cand ? cmp_idx_reg : best_idx_reg;
        best_now     = cand ? rd_data : best_reg;
    end

    assign load_burst = (s_data.burst_len == '0) ? srtn_pkg::VAL_W'(1) : s_data.burst_len;
    assign new_resp   = sel_started_reg ? sel_reg.response
                      : srtn_pkg::sat_out(time_reg - srtn_pkg::TIME_W'(sel_reg.arrival));
    assign add_w      = srtn_pkg::sum_add(tot_w_reg, res_reg.waiting);
    assign add_t      = srtn_pkg::sum_add(tot_t_reg, res_reg.turnaround);
    assign add_r      = srtn_pkg::sum_add(tot_r_reg, res_reg.response);

    assign s_ready   = (state_reg == IDLE);
    assign rd_addr   = rd_idx_reg;
    assign res.valid = (state_reg == EMIT);
    assign res.item  = res_reg;

    always_comb begin
        state_next       = state_reg;
        loaded_next      = loaded_reg;
        done_next        = done_reg;
        time_next        = time_reg;
        tot_w_next       = tot_w_reg;
        tot_t_next       = tot_t_reg;
        tot_r_next       = tot_r_reg;
        started_next     = started_reg;
        rd_idx_next      = rd_idx_reg;
        cmp_valid_next   = 1'b0;
        cmp_idx_next     = cmp_idx_reg;
        found_next       = found_reg;
        best_idx_next    = best_idx_reg;
        best_next        = best_reg;
        sel_idx_next     = sel_idx_reg;
        sel_next         = sel_reg;
        sel_started_next = sel_started_reg;
        tat_next         = tat_reg;
        rt_next          = rt_reg;
        res_next         = res_reg;
        wr               = '0;

        unique case (state_reg)
            IDLE: begin
                if (s_valid) begin
                    if (loaded_reg < srtn_pkg::CNT_W'(srtn_pkg::MAX_PROCS)) begin
                        wr.en             = 1'b1;
                        wr.addr           = loaded_reg[srtn_pkg::IDX_W-1:0];
                        wr.data.arrival   = s_data.arr_tick;
                        wr.data.burst     = load_burst;
                        wr.data.remaining = load_burst;
                        wr.data.response  = '0;
                        started_next[loaded_reg[srtn_pkg::IDX_W-1:0]] = 1'b0;
                        loaded_next       = loaded_reg + 1'b1;
                    end
                    if (s_data.last_process) begin
                        rd_idx_next = '0;
                        found_next  = 1'b0;
                        state_next  = SCAN;
                    end
                end
            end
            SCAN: begin
                found_next     = found_now;
                best_idx_next  = best_idx_now;
                best_next      = best_now;
                cmp_valid_next = 1'b1;
                cmp_idx_next   = rd_idx_reg;
                rd_idx_next    = rd_idx_reg + 1'b1;
                if (srtn_pkg::CNT_W'(rd_idx_reg) == loaded_reg - 1'b1) begin
                    state_next = DECIDE;
                end
            end
            DECIDE: begin
                found_next  = 1'b0;
                rd_idx_next = '0;
                if (!found_now) begin
                    // idle tick
                    time_next  = time_reg + 1'b1;
                    state_next = SCAN;
                end else begin
                    sel_idx_next     = best_idx_now;
                    sel_next         = best_now;
                    sel_started_next = started_reg[best_idx_now];
                    state_next       = UPDATE;
                end
            end
            UPDATE: begin
                wr.en                  = 1'b1;
                wr.addr                = sel_idx_reg;
                wr.data                = sel_reg;
                wr.data.remaining      = sel_reg.remaining - 1'b1;
                wr.data.response       = new_resp;
                started_next[sel_idx_reg] = 1'b1;
                rt_next                = new_resp;
                tat_next  = time_reg - srtn_pkg::TIME_W'(sel_reg.arrival) + 1'b1;
                time_next = time_reg + 1'b1;
                if (sel_reg.remaining == srtn_pkg::VAL_W'(1)) begin
                    state_next = FIN;
                end else begin
                    state_next = SCAN;
                end
            end
            FIN: begin
                res_next.process_number = srtn_pkg::PNUM_W'(int'(sel_idx_reg) + 1);
                res_next.turnaround     = srtn_pkg::sat_out(tat_reg);
                res_next.waiting        =
                    srtn_pkg::sat_out(tat_reg - srtn_pkg::TIME_W'(sel_reg.burst));
                res_next.response       = rt_reg;
                res_next.sum_waiting    = '0;
                res_next.sum_turnaround = '0;
                res_next.sum_response   = '0;
                res_next.final_result   = (done_reg + 1'b1 == loaded_reg);
                done_next               = done_reg + 1'b1;
                state_next              = SUMS;
            end
            SUMS: begin
                tot_w_next = add_w;
                tot_t_next = add_t;
                tot_r_next = add_r;
                if (res_reg.final_result) begin
                    res_next.sum_waiting    = add_w;
                    res_next.sum_turnaround = add_t;
                    res_next.sum_response   = add_r;
                end
                state_next = EMIT;
            end
            EMIT: begin
                if (slot_free) begin
                    rd_idx_next = '0;
                    if (res_reg.final_result) begin
                        // run over, back to an empty batch
                        started_next = '0;
                        loaded_next  = '0;
                        done_next    = '0;
                        time_next    = '0;
                        tot_w_next   = '0;
                        tot_t_next   = '0;
                        tot_r_next   = '0;
                        state_next   = IDLE;
                    end else begin
                        state_next = SCAN;
                    end
                end
            end
            default: state_next = IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= IDLE;
            loaded_reg    <= '0;
            done_reg      <= '0;
            time_reg      <= '0;
            tot_w_reg     <= '0;
            tot_t_reg     <= '0;
            tot_r_reg     <= '0;
            started_reg   <= '0;
            rd_idx_reg    <= '0;
            cmp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end else begin
            state_reg     <= state_next;
            loaded_reg    <= loaded_next;
            done_reg      <= done_next;
            time_reg      <= time_next;
            tot_w_reg     <= tot_w_next;
            tot_t_reg     <= tot_t_next;
            tot_r_reg     <= tot_r_next;
            started_reg   <= started_next;
            rd_idx_reg    <= rd_idx_next;
            cmp_valid_reg <= cmp_valid_next;
            found_reg     <= found_next;
        end
        cmp_idx_reg     <= cmp_idx_next;
        best_idx_reg    <= best_idx_next;
        best_reg        <= best_next;
        sel_idx_reg     <= sel_idx_next;
        sel_reg         <= sel_next;
        sel_started_reg <= sel_started_next;
        tat_reg         <= tat_next;
        rt_reg          <= rt_next;
        res_reg         <= res_next;
    end

endmodule

// File: sv/srtn_schedule_sim.sv
// top level of the shortest-remaining-time-first schedule simulator
//
//  channel  direction  ports                      transfer carries
//  s_       in         s_valid s_ready s_data     one process record
//  m_       out        m_valid m_ready m_data     one completion result
//
// a record that is not last is accepted whenever s_ready is high; records load back to back
// the last record starts the run; each tick scans the loaded entries through
// the memory read port and writes back the chosen entry; an idle tick writes nothing
// a completion passes through the FIN, SUMS and EMIT states before the result reaches the output register
// s_ready stays low for the whole run; m_ready low holds the run at the result
// reset clears counters, time, sums and started flags; records need no clearing
module srtn_schedule_sim (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  srtn_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output srtn_pkg::out_item_t m_data
);

    srtn_pkg::mem_wr_t          wr;
    logic [srtn_pkg::IDX_W-1:0] rd_addr;
    srtn_pkg::entry_t           rd_data;
    srtn_pkg::res_t             res;
    logic                       slot_free;
    logic                       out_valid_reg;
    srtn_pkg::out_item_t        out_reg;

    srtn_store u_store (
        .aclk    (aclk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    srtn_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .wr        (wr),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .res       (res),
        .slot_free (slot_free)
    );

    // output register
    assign slot_free = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (slot_free) begin
            out_valid_reg <= res.valid;
        end
        if (slot_free && res.valid) begin
            out_reg <= res.item;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    a_wait_le_tat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.waiting <= m_data.turnaround))
        else $error("waiting exceeds turnaround");

    a_resp_le_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.response <= m_data.waiting))
        else $error("response exceeds waiting");

    a_sums_only_final: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.final_result) |->
            (m_data.sum_waiting == '0 && m_data.sum_turnaround == '0
             && m_data.sum_response == '0))
        else $error("sums on a non-final result");

    a_no_load_while_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid |-> !s_ready)
        else $error("input open while a result is pending");

endmodule
